@@ design/its_pkg.sv @@
// Package for the interval time statistics block: command codes, weight
// constants, the statistics state record and its clearing function.
// Used by its_update and interval_time_statistics; depends on nothing.
package its_pkg;

  localparam int unsigned TS_W     = 32;
  localparam int unsigned AVG_W    = 48;
  localparam int unsigned TOTAL_W  = 64;
  localparam int unsigned WEIGHT_W = 17;

  // Unity weight in Q1.16 and the weight loaded at reset (about 0.9).
  localparam logic [WEIGHT_W-1:0] ONE_Q16      = 17'h10000;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd58982;

  // Rounding constant added before the final shift right by 16.
  localparam logic [15:0] HALF_Q16 = 16'h8000;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_END   = 1'b1
  } cmd_t;

  typedef struct packed {
    logic               awaiting_end;
    logic [TS_W-1:0]    start_stamp;
    logic               have_extremes;
    logic [TS_W-1:0]    min_value;
    logic [TS_W-1:0]    max_value;
    logic [AVG_W-1:0]   average_value;
    logic [TOTAL_W-1:0] total_sum;
    logic [TS_W-1:0]    count_value;
    logic [TS_W-1:0]    last_value;
  } stats_t;

  typedef struct packed {
    logic interval_done;
    logic sequence_error;
  } flags_t;

  // A clear keeps the running total and the last start stamp.
  function automatic stats_t clear_stats(stats_t s);
    stats_t r;
    r               = s;
    r.awaiting_end  = 1'b0;
    r.have_extremes = 1'b0;
    r.min_value     = '0;
    r.max_value     = '0;
    r.average_value = '0;
    r.count_value   = '0;
    r.last_value    = '0;
    return r;
  endfunction

endpackage

@@ design/its_update.sv @@
// Combinational update of the interval statistics for one marker item.
// Depends on its_pkg for the state record, command codes and constants.
module its_update import its_pkg::*; (
  input  stats_t              stats,
  input  cmd_t                command,
  input  logic [TS_W-1:0]     timestamp_us,
  input  logic [WEIGHT_W-1:0] old_weight,
  output stats_t              stats_next,
  output flags_t              flags
);

  logic [TS_W-1:0]     interval;
  logic [WEIGHT_W-1:0] w_sat;
  logic [WEIGHT_W-1:0] w_new;
  logic [AVG_W-1:0]    avg_base;
  logic [64:0]         prod_old;
  logic [48:0]         prod_new;
  logic [65:0]         blend_sum;
  logic [AVG_W-1:0]    avg_blend;

  assign interval = timestamp_us - stats.start_stamp;
  assign w_sat    = (old_weight > ONE_Q16) ? ONE_Q16 : old_weight;
  assign w_new    = ONE_Q16 - w_sat;

  // The first interval after a clear seeds the average with itself, which
  // makes the blend return that interval exactly.
  assign avg_base = stats.have_extremes ? stats.average_value : {interval, 16'h0000};

  assign prod_old  = 65'(avg_base) * 65'(w_sat);
  assign prod_new  = 49'(interval) * 49'(w_new);
  assign blend_sum = 66'(prod_old) + 66'({prod_new, 16'h0000}) + 66'(HALF_Q16);
  assign avg_blend = blend_sum[63:16];

  always_comb begin
    stats_next = stats;
    flags      = '0;
    if (command == CMD_START) begin
      if (stats.awaiting_end) begin
        stats_next           = clear_stats(stats);
        flags.sequence_error = 1'b1;
      end
      stats_next.start_stamp  = timestamp_us;
      stats_next.awaiting_end = 1'b1;
    end else if (!stats.awaiting_end) begin
      stats_next           = clear_stats(stats);
      flags.sequence_error = 1'b1;
    end else begin
      stats_next.awaiting_end = 1'b0;
      stats_next.count_value  = stats.count_value + 32'd1;
      if (!stats.have_extremes) begin
        stats_next.min_value     = interval;
        stats_next.max_value     = interval;
        stats_next.have_extremes = 1'b1;
      end else if (interval < stats.min_value) begin
        stats_next.min_value = interval;
      end else if (interval > stats.max_value) begin
        stats_next.max_value = interval;
      end
      stats_next.total_sum     = stats.total_sum + 64'(interval);
      stats_next.average_value = avg_blend;
      stats_next.last_value    = interval;
      flags.interval_done      = 1'b1;
    end
  end

endmodule

@@ design/interval_time_statistics.sv @@
// Interval time statistics: pairs start and end markers and keeps min, max,
// count, running total and a moving average of the measured intervals.
// An item passes through the input register, then the statistics registers,
// which also form the result register; one item is accepted every cycle while
// the result side takes them. Synchronous active high reset clears the
// statistics, the total and the pipeline, and loads the weight register with
// about 0.9 in Q1.16.
module interval_time_statistics import its_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // Input items.
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [31:0]         s_tdata,   // [31:0] timestamp_us
  input  logic                s_tuser,   // [0] command (0 start, 1 end)
  // Result items.
  output logic                m_tvalid,
  input  logic                m_tready,
  // [31:0] last_interval, [63:32] min_interval, [95:64] max_interval,
  // [143:96] average_interval, [207:144] total_time, [239:208] interval_count
  output logic [239:0]        m_tdata,
  output logic [1:0]          m_tuser,   // [0] interval_done, [1] sequence_error
  // Weight register write.
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [WEIGHT_W-1:0] cfg_data   // old_weight, Q1.16
);

  // Input register. The item waits here and is applied to the statistics when
  // the result register is free or being emptied.
  logic            in_valid;
  cmd_t            in_cmd;
  logic [TS_W-1:0] in_stamp;

  // The statistics registers double as the result register: while a result
  // is held, no new item is applied, so they keep its values.
  stats_t              stats;
  stats_t              stats_next;
  flags_t              flags;
  flags_t              flags_next;
  logic                out_valid;
  logic [WEIGHT_W-1:0] old_weight;
  logic                advance;

  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_cmd   <= cmd_t'(s_tuser);
      in_stamp <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      old_weight <= WEIGHT_RESET;
    end else if (cfg_valid) begin
      old_weight <= cfg_data;
    end
  end

  its_update u_update (
    .stats        (stats),
    .command      (in_cmd),
    .timestamp_us (in_stamp),
    .old_weight   (old_weight),
    .stats_next   (stats_next),
    .flags        (flags_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stats     <= '0;
      flags     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        stats <= stats_next;
        flags <= flags_next;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = {flags.sequence_error, flags.interval_done};
  assign m_tdata  = {stats.count_value, stats.total_sum, stats.average_value,
                     stats.max_value, stats.min_value, stats.last_value};

endmodule
